// ----- hdl/nntb_pkg.sv -----
// Shared widths and the controller/datapath command and status types.
`default_nettype none
package nntb_pkg;
	localparam int CITY_ID_W = 16;
	localparam int COORD_W   = 16;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 23;
	localparam int DIST_W    = 17;
	localparam int SUMSQ_W   = 34;
	localparam int RT_STAGES = 17;

	typedef struct packed {
		logic take;
		logic emit;
		logic emit_final;
		logic scan_start;
		logic scan_close;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic accept_last;
		logic last_pos;
		logic out_free;
		logic scan_done;
	} stat_t;
endpackage
`default_nettype wire

// ----- hdl/nntb_if.sv -----
// Channel interfaces: city input and tour result.
`default_nettype none
interface nntb_city_if;
	logic                                 valid;
	logic                                 ready;
	logic        [nntb_pkg::CITY_ID_W-1:0] city_id;
	logic signed [nntb_pkg::COORD_W-1:0]   coord_x;
	logic signed [nntb_pkg::COORD_W-1:0]   coord_y;
	logic                                 last_city;
	modport source (output valid, city_id, coord_x, coord_y, last_city, input ready);
	modport sink (input valid, city_id, coord_x, coord_y, last_city, output ready);
endinterface

interface nntb_tour_if;
	logic                            valid;
	logic                            ready;
	logic [nntb_pkg::CITY_ID_W-1:0]   tour_city_id;
	logic [nntb_pkg::POS_W-1:0]       tour_position;
	logic [nntb_pkg::LEN_W-1:0]       tour_length;
	logic                            end_of_tour;
	logic                            cities_dropped;
	modport source (output valid, tour_city_id, tour_position, tour_length, end_of_tour,
		cities_dropped, input ready);
	modport sink (input valid, tour_city_id, tour_position, tour_length, end_of_tour,
		cities_dropped, output ready);
endinterface
`default_nettype wire

// ----- hdl/nntb_isqrt.sv -----
// Pipelined rounded integer square root, one bit pair per stage.
`default_nettype none
module nntb_isqrt #(
	parameter int TAG_W = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld,
	input  wire logic [nntb_pkg::SUMSQ_W-1:0]  sumsq,
	input  wire logic [TAG_W-1:0]              tag,
	output logic                               dist_vld,
	output logic      [nntb_pkg::DIST_W-1:0]   root,
	output logic      [TAG_W-1:0]              dist_tag
);
	localparam int N = nntb_pkg::RT_STAGES;
	localparam int W = nntb_pkg::SUMSQ_W;

	logic [W-1:0]     rem_s [N+1];
	logic [W-1:0]     res_s [N+1];
	logic [TAG_W-1:0] tag_s [N+1];
	logic [N:0]       vld_s;

	assign rem_s[0] = sumsq;
	assign res_s[0] = '0;
	assign tag_s[0] = tag;
	assign vld_s[0] = vld;

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - j));
		logic [W-1:0] trial;
		assign trial = res_s[j] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[j+1] <= tag_s[j];
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				res_s[j+1] <= (res_s[j] >> 1) + BIT;
			end else begin
				rem_s[j+1] <= rem_s[j];
				res_s[j+1] <= res_s[j] >> 1;
			end
		end
	end

	// Round up when the remainder exceeds the floor root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_vld <= 1'b0;
		end else begin
			dist_vld <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		root     <= nntb_pkg::DIST_W'(res_s[N] + W'(rem_s[N] > res_s[N]));
		dist_tag <= tag_s[N];
	end
endmodule
`default_nettype wire

// ----- hdl/nntb_dp.sv -----
// Datapath: city store, visited flags, distance pipeline, best search, output register.
`default_nettype none
module nntb_dp #(
	parameter int MAX_CITIES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	nntb_city_if.sink           cities,
	nntb_tour_if.source         tour,
	input  wire nntb_pkg::cmd_t cmd,
	output nntb_pkg::stat_t     st
);
	localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int TAG_W = IDX_W + 2;
	localparam int CW    = nntb_pkg::COORD_W;
	localparam int DW    = nntb_pkg::DIST_W;

	logic [nntb_pkg::CITY_ID_W-1:0] mem_id [MAX_CITIES];
	logic [CW-1:0]                  mem_x  [MAX_CITIES];
	logic [CW-1:0]                  mem_y  [MAX_CITIES];

	logic [CNT_W-1:0]         cnt_q, n_q;
	logic                     ovf_q;
	logic [IDX_W-1:0]         cur_q, k_q;
	logic [MAX_CITIES-1:0]    visited_q;
	logic [nntb_pkg::LEN_W-1:0] run_q;

	logic                     accept, room;
	logic [CNT_W-1:0]         cnt_next;
	logic [IDX_W-1:0]         start_idx;

	assign cities.ready = cmd.take;
	assign accept       = cities.valid & cmd.take;
	assign room         = cnt_q < CNT_W'(MAX_CITIES);
	assign cnt_next     = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign start_idx    = IDX_W'(cnt_next - CNT_W'(1));

	// Scan issue
	logic             scan_act_q, scan_close_q;
	logic [IDX_W-1:0] iss_q, tok_idx;
	logic             tok_cand, tok_last;

	assign tok_idx  = scan_close_q ? IDX_W'(n_q - CNT_W'(1)) : iss_q;
	assign tok_cand = scan_close_q | ~visited_q[iss_q];
	assign tok_last = scan_close_q | ((CNT_W'(iss_q) + CNT_W'(1)) == n_q);

	// Store: one write port, scan read port and current-city read port
	logic [nntb_pkg::CITY_ID_W-1:0] cur_id_q;
	logic signed [CW-1:0]           cur_x_q, cur_y_q;
	logic signed [CW-1:0]           rx_s1, ry_s1;

	always_ff @(posedge clk) begin
		if (accept && room) begin
			mem_id[cnt_q[IDX_W-1:0]] <= cities.city_id;
			mem_x[cnt_q[IDX_W-1:0]]  <= cities.coord_x;
			mem_y[cnt_q[IDX_W-1:0]]  <= cities.coord_y;
		end
		rx_s1    <= mem_x[tok_idx];
		ry_s1    <= mem_y[tok_idx];
		cur_id_q <= mem_id[cur_q];
		cur_x_q  <= mem_x[cur_q];
		cur_y_q  <= mem_y[cur_q];
	end

	// Best-candidate tracking
	logic          found_q, done_q;
	logic [DW-1:0] best_d_q;
	logic [IDX_W-1:0] best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			n_q          <= '0;
			ovf_q        <= 1'b0;
			cur_q        <= '0;
			k_q          <= '0;
			visited_q    <= '0;
			run_q        <= '0;
			scan_act_q   <= 1'b0;
			scan_close_q <= 1'b0;
			iss_q        <= '0;
		end else begin
			if (accept) begin
				if (room) begin
					cnt_q <= cnt_next;
				end else begin
					ovf_q <= 1'b1;
				end
				if (cities.last_city) begin
					n_q       <= cnt_next;
					cur_q     <= start_idx;
					k_q       <= '0;
					visited_q <= MAX_CITIES'(1) << start_idx;
					run_q     <= '0;
				end
			end
			if (cmd.advance) begin
				run_q              <= run_q + nntb_pkg::LEN_W'(best_d_q);
				visited_q[best_q]  <= 1'b1;
				cur_q              <= best_q;
				k_q                <= k_q + IDX_W'(1);
			end
			if (cmd.emit_final) begin
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
				visited_q <= '0;
				run_q     <= '0;
			end
			if (cmd.scan_start) begin
				scan_act_q   <= 1'b1;
				scan_close_q <= cmd.scan_close;
				iss_q        <= '0;
			end else if (scan_act_q) begin
				if (tok_last) begin
					scan_act_q <= 1'b0;
				end else begin
					iss_q <= iss_q + IDX_W'(1);
				end
			end
		end
	end

	// Distance pipeline: read, difference, squares, sum
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CW:0]     dx_s2, dy_s2, dy_s3;
	logic [nntb_pkg::SUMSQ_W-1:0] sqx_s3, sqx_s4, sqy_s4, ss_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= scan_act_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= {tok_cand, tok_last, tok_idx};
		tag_s2 <= tag_s1;
		dx_s2  <= (CW+1)'(cur_x_q) - (CW+1)'(rx_s1);
		dy_s2  <= (CW+1)'(cur_y_q) - (CW+1)'(ry_s1);
		tag_s3 <= tag_s2;
		sqx_s3 <= nntb_pkg::SUMSQ_W'(dx_s2 * dx_s2);
		dy_s3  <= dy_s2;
		tag_s4 <= tag_s3;
		sqy_s4 <= nntb_pkg::SUMSQ_W'(dy_s3 * dy_s3);
		sqx_s4 <= sqx_s3;
		tag_s5 <= tag_s4;
		ss_s5  <= sqx_s4 + sqy_s4;
	end

	logic             d_vld;
	logic [DW-1:0]    d_val;
	logic [TAG_W-1:0] d_tag;

	nntb_isqrt #(.TAG_W(TAG_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_s5),
		.sumsq    (ss_s5),
		.tag      (tag_s5),
		.dist_vld (d_vld),
		.root     (d_val),
		.dist_tag (d_tag)
	);

	// Strict less-than keeps the earliest slot on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= d_vld & d_tag[IDX_W];
			if (d_vld && d_tag[IDX_W+1] && (!found_q || d_val < best_d_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_start && d_vld && d_tag[IDX_W+1] && (!found_q || d_val < best_d_q)) begin
			best_d_q <= d_val;
			best_q   <= d_tag[IDX_W-1:0];
		end
	end

	// Output register
	logic out_vld_q;
	assign tour.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_final) begin
			out_vld_q <= 1'b1;
		end else if (tour.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.emit_final) begin
			tour.tour_city_id   <= cur_id_q;
			tour.tour_position  <= nntb_pkg::POS_W'(k_q);
			tour.cities_dropped <= ovf_q;
			tour.end_of_tour    <= cmd.emit_final;
			tour.tour_length    <= cmd.emit_final ?
				run_q + nntb_pkg::LEN_W'(best_d_q) : '0;
		end
	end

	assign st.accept_last = accept & cities.last_city;
	assign st.last_pos    = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
	assign st.out_free    = ~out_vld_q | tour.ready;
	assign st.scan_done   = done_q;
endmodule
`default_nettype wire

// ----- hdl/nntb_ctrl.sv -----
// Controller: sequences loading, per-step scans, emission and the closing edge.
`default_nettype none
module nntb_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nntb_pkg::stat_t st,
	output nntb_pkg::cmd_t       cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FETCH = 6'b000010,
		S_EMIT  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_CLOSE = 6'b010000,
		S_FINAL = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (st.accept_last) state_d = S_FETCH;
			end
			S_FETCH: state_d = S_EMIT;
			S_EMIT: begin
				if (st.last_pos) begin
					cmd.scan_start = 1'b1;
					cmd.scan_close = 1'b1;
					state_d        = S_CLOSE;
				end else if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_done) begin
					cmd.advance = 1'b1;
					state_d     = S_FETCH;
				end
			end
			S_CLOSE: begin
				if (st.scan_done) state_d = S_FINAL;
			end
			S_FINAL: begin
				if (st.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/nearest_neighbor_tour_builder.sv -----
// Top level: greedy nearest-neighbor tour builder over a loaded city set.
//
// Usage: send cities on "cities" (valid/ready), one transaction each, with
// last_city set on the final one. Up to MAX_CITIES cities are stored; later
// ones are dropped and flag cities_dropped on every result of that tour.
// Loading takes cities back to back. The transaction marked last starts the
// build; "cities" holds ready low until the final result is loaded.
// Results leave on "tour", one transaction per stored city in tour order,
// starting at the last stored city; the final one has end_of_tour set and
// carries the closed tour length.
// Search: each tour step scans all N stored cities through one distance
// pipeline (difference, two squares, sum, 17-stage square root, round);
// the closing edge sends only the start city through it.
// A stalled receiver holds the output register: the scan after a result
// still runs, then the controller starts no further step (bar the closing
// scan) until the register frees. Input stays stalled for the whole build.
// Reset clears the city count, visited flags, length and the state machine.
`default_nettype none
module nearest_neighbor_tour_builder #(
	parameter int MAX_CITIES = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	nntb_city_if.sink   cities,
	nntb_tour_if.source tour
);
	nntb_pkg::cmd_t  cmd;
	nntb_pkg::stat_t st;

	// Sequence the tour: scan, pick, emit, advance.
	nntb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// Hold the store, compute distances, drive both channels.
	nntb_dp #(.MAX_CITIES(MAX_CITIES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cities (cities),
		.tour   (tour),
		.cmd    (cmd),
		.st     (st)
	);
endmodule
`default_nettype wire

// ----- hdl/nntb_checker.sv -----
// Port-level checker for the tour builder and its bind.
`default_nettype none
module nntb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_id,
	input wire logic [5:0]  out_pos,
	input wire logic [22:0] out_len,
	input wire logic        out_eot
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_pos))
		else $error("stalled result changed");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_eot |-> out_len == 23'd0)
		else $error("length on non-final result");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_eot |=> !out_valid || out_pos == $past(out_pos) + 6'd1)
		else $error("tour position skipped");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_eot |=> !out_valid)
		else $error("result right after tour end");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_eot |-> !in_ready)
		else $error("input taken during tour");
endmodule

bind nearest_neighbor_tour_builder nntb_checker u_nntb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (cities.ready),
	.out_valid (tour.valid),
	.out_ready (tour.ready),
	.out_id    (tour.tour_city_id),
	.out_pos   (tour.tour_position),
	.out_len   (tour.tour_length),
	.out_eot   (tour.end_of_tour)
);
`default_nettype wire
